/* design/tpsh_pkg.sv */
package tpsh_pkg;

    // Field widths of the byte and result beats.
    localparam int BYTE_W = 8;
    localparam int HASH_W = 32;

    // Default capacity of the byte store.
    localparam int MAX_BYTES_DEF = 256;

    // Hash constants.
    localparam logic [HASH_W-1:0] HASH_SEED = 32'hd2d8_4a61;
    localparam int SHIFT_R = 5;
    localparam int SHIFT_L = 7;

    // One shift-add-xor step; the byte is sign-extended before the add.
    function automatic logic [HASH_W-1:0] mix_byte(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] ext;
        ext = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        return h ^ ((h >> SHIFT_R) + ext + (h << SHIFT_L));
    endfunction

endpackage

/* design/tpsh_in_if.sv */
interface tpsh_in_if;
    import tpsh_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

/* design/tpsh_out_if.sv */
interface tpsh_out_if;
    import tpsh_pkg::*;

    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;
    logic              too_long;

    modport source (output valid, output hash_value, output too_long, input ready);
    modport sink   (input valid, input hash_value, input too_long, output ready);
endinterface

/* design/two_pass_string_hash_top.sv */
// After its last byte beat, a name of n stored bytes gives its result beat
// through the reverse pass, the forward pass, the drain and the done states;
// a name that overflows the store goes straight to the done state. The input
// takes one byte beat per cycle while loading; the two hash passes read the
// single port of the byte store once per byte each. Reset (i_rst_n, synchronous, active
// low) clears the count, the overflow flag and the result slot, and sets the hash to its seed.
module two_pass_string_hash_top #(
    parameter int MAX_BYTES = tpsh_pkg::MAX_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpsh_in_if.sink    i_in,
    tpsh_out_if.source o_out
);
    import tpsh_pkg::*;

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_REV   = 5'b00010,
        ST_FWD   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic              r_res_ovf, n_res_ovf;
    logic [AW-1:0]     r_raddr, n_raddr;
    logic [AW-1:0]     r_last_addr, n_last_addr;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic              r_dvld;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_out_valid, n_out_valid;
    logic [HASH_W-1:0] r_out_hash, n_out_hash;
    logic              r_out_too_long, n_out_too_long;

    logic              acc;
    logic              full;
    logic              we;
    logic              rd_en;
    logic              out_free;

    logic [BYTE_W-1:0] mem [MAX_BYTES];

    assign i_in.ready       = (r_state == ST_LOAD);
    assign acc              = i_in.valid && i_in.ready;
    assign full             = (r_count == CW'(MAX_BYTES));
    assign we               = acc && !full;
    assign rd_en            = (r_state == ST_REV) || (r_state == ST_FWD);
    assign out_free         = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;
    assign o_out.too_long   = r_out_too_long;

    // Byte store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_count[AW-1:0]] <= i_in.byte_value;
        end
        if (rd_en) begin
            r_rdata <= mem[r_raddr];
        end
    end

    // Sequencer: load bytes, walk the store downward, then upward, then emit; an overflowed name skips both walks.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_ovf          = r_ovf;
        n_res_ovf      = r_res_ovf;
        n_raddr        = r_raddr;
        n_last_addr    = r_last_addr;
        n_hash         = r_hash;
        n_out_valid    = r_out_valid;
        n_out_hash     = r_out_hash;
        n_out_too_long = r_out_too_long;

        // A read issued last cycle returns its byte now.
        if (r_dvld) begin
            n_hash = mix_byte(r_hash, r_rdata);
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (acc) begin
                    if (!full) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_byte) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        if (r_ovf || full) begin
                            n_res_ovf = 1'b1;
                            n_state   = ST_DONE;
                        end else begin
                            n_res_ovf   = 1'b0;
                            n_raddr     = r_count[AW-1:0];
                            n_last_addr = r_count[AW-1:0];
                            n_state     = ST_REV;
                        end
                    end
                end
            end
            ST_REV: begin
                if (r_raddr == '0) begin
                    n_state = ST_FWD;
                end else begin
                    n_raddr = r_raddr - AW'(1);
                end
            end
            ST_FWD: begin
                if (r_raddr == r_last_addr) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_raddr = r_raddr + AW'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_hash     = r_res_ovf ? '0 : r_hash;
                    n_out_too_long = r_res_ovf;
                    n_hash         = HASH_SEED;
                    n_state        = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_hash      <= HASH_SEED;
            r_dvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_hash      <= n_hash;
            r_dvld      <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res_ovf      <= n_res_ovf;
        r_raddr        <= n_raddr;
        r_last_addr    <= n_last_addr;
        r_out_hash     <= n_out_hash;
        r_out_too_long <= n_out_too_long;
    end

    // The byte count never passes the store capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BYTES))
        else $error("byte count beyond store capacity");

    // Outside loading, the next name starts from an empty store.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_LOAD |-> (r_count == '0) && !r_ovf)
        else $error("count not cleared while hashing");

    // Each new name starts hashing from the seed.
    a_seed_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> r_hash == HASH_SEED)
        else $error("hash not at seed while loading");

    // Read data only comes back from a pass state.
    a_read_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvld |-> $past(r_state == ST_REV || r_state == ST_FWD))
        else $error("read data without a read");

    // An overflowed name reports a zero hash.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_too_long |-> r_out_hash == '0)
        else $error("too_long result with nonzero hash");

endmodule
